/* sv/assert_macros.svh */
// Assertion macros used by the top level of the transfer sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define CHK_IMPL(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define CHK_NEXT(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);

`endif

/* sv/i2crts_pkg.sv */
// Types, codes and constants of the I2C register transfer sequencer.
package i2crts_pkg;

  // Longest transfer, in data bytes
  localparam logic [7:0] MAX_LEN = 8'd255;
  // Register address auto-increment bit for multi-byte transfers
  localparam logic [7:0] AUTO_INC = 8'h80;
  localparam logic [7:0] ONE_BYTE = 8'd1;

  // Command codes
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // Bus engine actions
  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_START  = 3'd1;
  localparam logic [2:0] ACT_RSTART = 3'd2;
  localparam logic [2:0] ACT_TX     = 3'd3;
  localparam logic [2:0] ACT_RXEN   = 3'd4;
  localparam logic [2:0] ACT_ACK    = 3'd5;
  localparam logic [2:0] ACT_STOP   = 3'd6;

  // Status codes
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;
  localparam logic [1:0] ST_FAIL = 2'd3;

  // Sequencer phases
  localparam logic [4:0] PH_IDLE       = 5'd0;
  localparam logic [4:0] PH_START      = 5'd1;
  localparam logic [4:0] PH_DEV_W      = 5'd2;
  localparam logic [4:0] PH_REG        = 5'd3;
  localparam logic [4:0] PH_REG_WAIT   = 5'd4;
  localparam logic [4:0] PH_WDATA      = 5'd5;
  localparam logic [4:0] PH_WDATA_WAIT = 5'd6;
  localparam logic [4:0] PH_RSTART     = 5'd7;
  localparam logic [4:0] PH_DEV_R      = 5'd8;
  localparam logic [4:0] PH_DEV_R_WAIT = 5'd9;
  localparam logic [4:0] PH_RXEN       = 5'd10;
  localparam logic [4:0] PH_RX_WAIT    = 5'd11;
  localparam logic [4:0] PH_ACK_WAIT   = 5'd12;
  localparam logic [4:0] PH_STOP_OK    = 5'd13;
  localparam logic [4:0] PH_END_OK     = 5'd14;
  localparam logic [4:0] PH_STOP_FAIL  = 5'd15;
  localparam logic [4:0] PH_END_FAIL   = 5'd16;
  localparam logic [4:0] PH_STOP_RETRY = 5'd17;
  localparam logic [4:0] PH_END_RETRY  = 5'd18;

  // One tick from the host and the bus engine
  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] dev_addr;
    logic [6:0] reg_addr;
    logic [7:0] byte_count;
    logic [7:0] write_byte;
    logic       done_req;
    logic       ack_missing;
    logic [7:0] rx_byte;
  } in_t;

  // Result of one tick
  typedef struct packed {
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic       ack_level;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic [7:0] byte_index;
    logic [1:0] status;
  } out_t;

  // Sequencer state
  typedef struct packed {
    logic [4:0] phase;
    logic       is_read;
    logic       pending;
    logic [6:0] saved_dev_addr;
    logic [6:0] saved_reg_addr;
    logic [7:0] saved_count;
    logic [7:0] byte_counter;
    logic [3:0] retry_counter;
  } state_t;

endpackage

/* sv/i2crts_step.sv */
// Next-state and action decode for one tick of the sequencer.
module i2crts_step (
  input  i2crts_pkg::state_t state,
  input  i2crts_pkg::in_t    req,
  input  logic [3:0]         max_retries,
  output i2crts_pkg::state_t state_next,
  output i2crts_pkg::out_t   res
);
  import i2crts_pkg::*;

  logic [7:0] cnt;
  logic [7:0] count_inc;

  // Length clamp for a new command
  always_comb begin
    cnt = req.byte_count;
    if (cnt == 8'd0) cnt = ONE_BYTE;
    if (cnt > MAX_LEN) cnt = MAX_LEN;
  end

  assign count_inc = state.byte_counter + 8'd1;

  // Phase decode
  always_comb begin
    state_next     = state;
    res            = '0;
    res.action     = ACT_NONE;
    res.status     = ST_BUSY;
    res.byte_index = state.byte_counter;
    case (state.phase)
      PH_IDLE: begin
        if (state.pending) begin
          state_next.phase = PH_START;
        end else if (req.mode == MODE_WRITE || req.mode == MODE_READ) begin
          state_next.pending        = 1'b1;
          state_next.is_read        = (req.mode == MODE_READ);
          state_next.saved_dev_addr = req.dev_addr;
          state_next.saved_reg_addr = req.reg_addr;
          state_next.saved_count    = cnt;
          state_next.phase          = PH_START;
        end else begin
          res.status = ST_IDLE;
        end
      end
      PH_START: begin
        res.action       = ACT_START;
        state_next.phase = PH_DEV_W;
      end
      PH_DEV_W: begin
        if (req.done_req) begin
          res.action       = ACT_TX;
          res.tx_byte      = {state.saved_dev_addr, 1'b0};
          state_next.phase = PH_REG;
        end
      end
      PH_REG: begin
        if (req.done_req) begin
          if (req.ack_missing) begin
            state_next.phase = (state.retry_counter < max_retries) ? PH_STOP_RETRY
                                                                   : PH_STOP_FAIL;
          end else begin
            state_next.retry_counter = 4'd0;
            res.action  = ACT_TX;
            res.tx_byte = {1'b0, state.saved_reg_addr} |
                          ((state.saved_count > ONE_BYTE) ? AUTO_INC : 8'd0);
            state_next.phase = PH_REG_WAIT;
          end
        end
      end
      PH_REG_WAIT: begin
        if (req.done_req) begin
          state_next.phase = req.ack_missing ? PH_STOP_FAIL :
                             (state.is_read ? PH_RSTART : PH_WDATA);
        end
      end
      PH_WDATA: begin
        res.action              = ACT_TX;
        res.tx_byte             = req.write_byte;
        state_next.byte_counter = count_inc;
        state_next.phase        = PH_WDATA_WAIT;
      end
      PH_WDATA_WAIT: begin
        if (req.done_req) begin
          if (req.ack_missing) state_next.phase = PH_STOP_FAIL;
          else state_next.phase = (state.byte_counter == state.saved_count) ? PH_STOP_OK
                                                                             : PH_WDATA;
        end
      end
      PH_RSTART: begin
        res.action       = ACT_RSTART;
        state_next.phase = PH_DEV_R;
      end
      PH_DEV_R: begin
        if (req.done_req) begin
          res.action       = ACT_TX;
          res.tx_byte      = {state.saved_dev_addr, 1'b1};
          state_next.phase = PH_DEV_R_WAIT;
        end
      end
      PH_DEV_R_WAIT: begin
        if (req.done_req) state_next.phase = req.ack_missing ? PH_STOP_FAIL : PH_RXEN;
      end
      PH_RXEN: begin
        res.action       = ACT_RXEN;
        state_next.phase = PH_RX_WAIT;
      end
      PH_RX_WAIT: begin
        if (req.done_req) begin
          res.rx_valid            = 1'b1;
          res.rx_data             = req.rx_byte;
          res.action              = ACT_ACK;
          res.ack_level           = (count_inc == state.saved_count);
          state_next.byte_counter = count_inc;
          state_next.phase        = PH_ACK_WAIT;
        end
      end
      PH_ACK_WAIT: begin
        if (req.done_req) begin
          state_next.phase = (state.byte_counter == state.saved_count) ? PH_STOP_OK
                                                                        : PH_RXEN;
        end
      end
      PH_STOP_OK: begin
        res.action       = ACT_STOP;
        state_next.phase = PH_END_OK;
      end
      PH_STOP_FAIL: begin
        res.action       = ACT_STOP;
        state_next.phase = PH_END_FAIL;
      end
      PH_END_OK: begin
        if (req.done_req) begin
          state_next.phase        = PH_IDLE;
          state_next.byte_counter = 8'd0;
          state_next.pending      = 1'b0;
          res.status              = ST_DONE;
        end
      end
      PH_END_FAIL: begin
        if (req.done_req) begin
          state_next.phase         = PH_IDLE;
          state_next.byte_counter  = 8'd0;
          state_next.retry_counter = 4'd0;
          state_next.pending       = 1'b0;
          res.status               = ST_FAIL;
        end
      end
      PH_STOP_RETRY: begin
        res.action               = ACT_STOP;
        state_next.retry_counter = state.retry_counter + 4'd1;
        state_next.phase         = PH_END_RETRY;
      end
      PH_END_RETRY: begin
        if (req.done_req) begin
          state_next.phase        = PH_IDLE;
          state_next.byte_counter = 8'd0;
        end
      end
      default: begin
        // Meaningless phase code: back to idle
        state_next.phase        = PH_IDLE;
        state_next.pending      = 1'b0;
        state_next.byte_counter = 8'd0;
        res.status              = ST_IDLE;
      end
    endcase
  end

endmodule

/* sv/i2crts_out_stage.sv */
// Result register that decouples the result side from the request side.
module i2crts_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  i2crts_pkg::out_t res,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output i2crts_pkg::out_t out_data
);
  import i2crts_pkg::*;

  // Free when empty or when the held result leaves this cycle
  assign in_ready = !out_valid || out_ready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res;
    end
  end

endmodule

/* sv/i2c_register_transfer_sequencer_core.sv */
// Top level of the I2C register transfer sequencer.
// Each accepted request is one tick of the sequencer: the phase logic updates the
// held state and the resulting bus action lands in the result register, so a
// result appears in the cycle after its request. One request is taken every clock;
// the result register is reloaded in the same cycle its previous result is taken,
// so only a stalled result side holds off new requests. max_retries resets to 3;
// the user writes it through cfg_we/cfg_wdata while no transfer is running (unchecked).
`include "assert_macros.svh"

module i2c_register_transfer_sequencer_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  i2crts_pkg::in_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output i2crts_pkg::out_t out_data,
  input  logic             cfg_we,
  input  logic [3:0]       cfg_wdata
);
  import i2crts_pkg::*;

  logic       in_fire;
  logic [3:0] max_retries;
  state_t     state;
  state_t     state_next;
  out_t       step_res;

  assign in_fire = in_valid && in_ready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_retries <= 4'd3;
    end else if (cfg_we) begin
      max_retries <= cfg_wdata;
    end
  end

  // Sequencer state, advanced once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  i2crts_step u_step (
    .state       (state),
    .req         (in_data),
    .max_retries (max_retries),
    .state_next  (state_next),
    .res         (step_res)
  );

  i2crts_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (in_fire),
    .res       (step_res),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Checks
  `CHK_NEXT(a_fire_gives_result, in_fire, out_valid, "accepted tick left no result")
  `CHK_IMPL(a_counter_bound, 1'b1, state.byte_counter <= state.saved_count, "byte counter ran past length")
  `CHK_IMPL(a_rx_with_ack, out_valid && out_data.rx_valid, out_data.action == ACT_ACK, "received byte without ack action")

endmodule
